// ===== rtl/lpfr_pkg.sv =====
// Shared types, constants and helpers for the loopback packet fan-out block.
// No dependencies; the control module and the top level refer to it by scoped names.
`default_nettype none

package lpfr_pkg;

    // Route table geometry
    localparam int ROUTE_SLOTS = 8;
    localparam int SLOT_W      = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;

    // At most this many copies leave for one packet
    localparam int MAX_COPIES  = 8;
    localparam int CNT_W       = $clog2(MAX_COPIES);

    // Configuration reset value: 127.0.0.1
    localparam logic [31:0] DEFAULT_MATCH = 32'h7f00_0001;

    // Header fields accepted for replication
    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam logic [3:0] IPV4_IHL     = 4'd5;

    // Request kinds
    localparam logic FUNC_ROUTE  = 1'b0;
    localparam logic FUNC_PACKET = 1'b1;

    // One route table entry
    typedef struct packed {
        logic [31:0] new_src;
        logic [31:0] new_dst;
        logic [47:0] smac;
        logic [47:0] dmac;
        logic [31:0] port;
    } t_route;

    // Map the 3-bit slot field onto a table index
    function automatic logic [SLOT_W-1:0] slot_of_index(input logic [2:0] idx);
        logic [SLOT_W+2:0] t;
        t = {{SLOT_W{1'b0}}, idx};
        return t[SLOT_W-1:0];
    endfunction

    // Low three bits of a table index, as reported on each copy
    function automatic logic [2:0] slot_low3(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+2:0] t;
        t = {3'b000, s};
        return t[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lpfr_if.sv =====
// Valid/ready channel interfaces for packet requests and outgoing copies.
// Depends on nothing; used by the control module and the top level.
`default_nettype none

interface lpfr_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [2:0]  slot_index;
    logic        slot_active;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] out_port;
    logic [63:0] head_words;
    logic [15:0] ttl_protocol;

    modport source (
        output valid, func, slot_index, slot_active, src_addr, dst_addr,
               src_mac, dst_mac, out_port, head_words, ttl_protocol,
        input  ready
    );
    modport sink (
        input  valid, func, slot_index, slot_active, src_addr, dst_addr,
               src_mac, dst_mac, out_port, head_words, ttl_protocol,
        output ready
    );
endinterface

interface lpfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  route_slot;
    logic [31:0] copy_port;
    logic [47:0] copy_src_mac;
    logic [47:0] copy_dst_mac;
    logic [31:0] copy_src_addr;
    logic [31:0] copy_dst_addr;
    logic [15:0] header_checksum;
    logic        last_copy;

    modport source (
        output valid, route_slot, copy_port, copy_src_mac, copy_dst_mac,
               copy_src_addr, copy_dst_addr, header_checksum, last_copy,
        input  ready
    );
    modport sink (
        input  valid, route_slot, copy_port, copy_src_mac, copy_dst_mac,
               copy_src_addr, copy_dst_addr, header_checksum, last_copy,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/loopback_packet_fanout_rewrite_top.sv =====
// Top level of the loopback packet fan-out with IPv4 header rewrite.
// Depends on lpfr_pkg, lpfr_if and lpfr_ctrl; holds the match register.
//
// Usage:
//   i_req carries requests. func 0 writes one route slot (active bit,
//   new addresses, MACs, port) and produces nothing. func 1 presents a
//   plain IPv4 header; if version is 4, ihl is 5 and the destination
//   equals match_address, one rewritten copy per active slot leaves on
//   o_copy in ascending slot order, at most eight, the final one marked.
//   The APB port writes and reads match_address at byte address 0.
// Timing:
//   A route write or a rejected packet leaves the block idle. An accepted
//   packet first forms the header sum in S_BASE, then emits one copy per
//   cycle while o_copy is not stalled; no new request is taken until the
//   walk ends. The single ones'-complement adder and the route RAM read
//   port set this pace. The first copy is registered after S_BASE and S_CALC.
// Reset and stalls:
//   Reset clears all route active bits and restores 127.0.0.1. If o_copy
//   stalls, the walk holds with the pending copy in the output register.
`default_nettype none

module loopback_packet_fanout_rewrite_top (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    lpfr_in_if.sink           i_req,
    lpfr_out_if.source        o_copy,
    input  wire  logic        psel,
    input  wire  logic        penable,
    input  wire  logic        pwrite,
    input  wire  logic [2:0]  paddr,
    input  wire  logic [31:0] pwdata,
    output logic       [31:0] prdata,
    output logic              pready
);
    localparam logic REG_MATCH = 1'b0;

    logic [31:0] r_match;
    logic        cfg_wr;

    // Register write on the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MATCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= lpfr_pkg::DEFAULT_MATCH;
        end else if (cfg_wr) begin
            r_match <= pwdata;
        end
    end

    // Read back
    assign prdata = (paddr[2] == REG_MATCH) ? r_match : '0;

    lpfr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_match_addr (r_match),
        .i_req        (i_req),
        .o_copy       (o_copy)
    );

endmodule

`default_nettype wire

// ===== rtl/lpfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the route table.
`default_nettype none

module lpfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire  logic                                        i_clk,
    input  wire  logic                                        i_we,
    input  wire  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  logic [WIDTH-1:0]                            i_wdata,
    input  wire  logic                                        i_re,
    input  wire  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic       [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lpfr_csum.sv =====
// Shared ones'-complement adder: adds five 16-bit words with end-around carry.
// No package use; serves both the header base sum and each copy's checksum.
`default_nettype none

module lpfr_csum (
    input  wire  logic [4:0][15:0] i_words,
    output logic       [15:0]      o_sum
);
    logic [18:0] raw;
    logic [16:0] fold1;

    // Sum the words, then fold the carries back in twice
    always_comb begin
        raw = 19'(i_words[0]) + 19'(i_words[1]) + 19'(i_words[2])
            + 19'(i_words[3]) + 19'(i_words[4]);
        fold1 = 17'(raw[15:0]) + 17'(raw[18:16]);
        o_sum = fold1[15:0] + 16'(fold1[16]);
    end

endmodule

`default_nettype wire

// ===== rtl/lpfr_ctrl.sv =====
// Sequencer: route writes, header check, slot walk and output register.
// Depends on lpfr_pkg, lpfr_if, lpfr_ram and lpfr_csum.
`default_nettype none

module lpfr_ctrl (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic [31:0] i_match_addr,
    lpfr_in_if.sink           i_req,
    lpfr_out_if.source        o_copy
);
    localparam int SW = lpfr_pkg::SLOT_W;
    localparam int NS = lpfr_pkg::ROUTE_SLOTS;
    localparam int CW = lpfr_pkg::CNT_W;

    typedef enum logic [1:0] {S_IDLE, S_BASE, S_CALC} t_state;

    t_state              r_state;
    logic [NS-1:0]       r_valid;
    logic [NS-1:0]       r_pend;
    logic [SW-1:0]       r_slot;
    logic [CW-1:0]       r_cnt;
    logic [63:0]         r_head;
    logic [15:0]         r_ttl;
    logic [15:0]         r_base;
    logic                r_out_valid;
    logic [2:0]          r_route_slot;
    logic [31:0]         r_copy_port;
    logic [47:0]         r_copy_src_mac;
    logic [47:0]         r_copy_dst_mac;
    logic [31:0]         r_copy_src_addr;
    logic [31:0]         r_copy_dst_addr;
    logic [15:0]         r_header_checksum;
    logic                r_last_copy;

    logic                accept;
    logic                hdr_ok;
    logic                wr_ok;
    logic [SW-1:0]       wr_slot;
    logic                ram_we;
    logic                ram_re;
    lpfr_pkg::t_route    wr_route;
    lpfr_pkg::t_route    rd_route;
    logic [SW-1:0]       pick_slot;
    logic [NS-1:0]       pend_rest;
    logic                out_free;
    logic                calc_go;
    logic                last_now;
    logic [4:0][15:0]    cs_words;
    logic [15:0]         cs_sum;

    // Request decode
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign hdr_ok      = (i_req.head_words[63:60] == lpfr_pkg::IPV4_VERSION)
                      && (i_req.head_words[59:56] == lpfr_pkg::IPV4_IHL)
                      && (i_req.dst_addr == i_match_addr);
    assign wr_slot     = lpfr_pkg::slot_of_index(i_req.slot_index);
    assign wr_ok       = int'(i_req.slot_index) < NS;
    assign ram_we      = accept && (i_req.func == lpfr_pkg::FUNC_ROUTE) && wr_ok;

    always_comb begin
        wr_route.new_src = i_req.src_addr;
        wr_route.new_dst = i_req.dst_addr;
        wr_route.smac    = i_req.src_mac;
        wr_route.dmac    = i_req.dst_mac;
        wr_route.port    = i_req.out_port;
    end

    // Pick the lowest pending slot and drop it from the set
    always_comb begin
        pick_slot = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                pick_slot = SW'(i);
            end
        end
        pend_rest = r_pend & (r_pend - NS'(1));
    end

    assign out_free = !r_out_valid || o_copy.ready;
    assign calc_go  = (r_state == S_CALC) && out_free;
    assign last_now = (r_pend == '0) || (r_cnt == CW'(lpfr_pkg::MAX_COPIES - 1));
    assign ram_re   = (r_state == S_BASE) || calc_go;

    // Route table
    lpfr_ram #(
        .WIDTH ($bits(lpfr_pkg::t_route)),
        .DEPTH (NS)
    ) u_route_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_slot),
        .i_wdata (wr_route),
        .i_re    (ram_re),
        .i_raddr (pick_slot),
        .o_rdata (rd_route)
    );

    // Steer the shared adder: header words first, then per-copy addresses
    always_comb begin
        if (r_state == S_BASE) begin
            cs_words = {r_head[63:48], r_head[47:32], r_head[31:16], r_head[15:0], r_ttl};
        end else begin
            cs_words = {r_base, rd_route.new_src[31:16], rd_route.new_src[15:0],
                        rd_route.new_dst[31:16], rd_route.new_dst[15:0]};
        end
    end

    lpfr_csum u_csum (
        .i_words (cs_words),
        .o_sum   (cs_sum)
    );

    // State, table valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load the output register on a new copy, drop it once taken
            if (calc_go) begin
                r_out_valid <= 1'b1;
            end else if (o_copy.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.func == lpfr_pkg::FUNC_ROUTE) begin
                            if (wr_ok) begin
                                r_valid[wr_slot] <= i_req.slot_active;
                            end
                        end else if (hdr_ok && (r_valid != '0)) begin
                            r_head  <= i_req.head_words;
                            r_ttl   <= i_req.ttl_protocol;
                            r_pend  <= r_valid;
                            r_cnt   <= '0;
                            r_state <= S_BASE;
                        end
                    end
                end
                S_BASE: begin
                    r_base  <= cs_sum;
                    r_slot  <= pick_slot;
                    r_pend  <= pend_rest;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (out_free) begin
                        r_route_slot      <= lpfr_pkg::slot_low3(r_slot);
                        r_copy_port       <= rd_route.port;
                        r_copy_src_mac    <= rd_route.smac;
                        r_copy_dst_mac    <= rd_route.dmac;
                        r_copy_src_addr   <= rd_route.new_src;
                        r_copy_dst_addr   <= rd_route.new_dst;
                        r_header_checksum <= ~cs_sum;
                        r_last_copy       <= last_now;
                        if (last_now) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_slot <= pick_slot;
                            r_pend <= pend_rest;
                            r_cnt  <= r_cnt + CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_copy.valid           = r_out_valid;
    assign o_copy.route_slot      = r_route_slot;
    assign o_copy.copy_port       = r_copy_port;
    assign o_copy.copy_src_mac    = r_copy_src_mac;
    assign o_copy.copy_dst_mac    = r_copy_dst_mac;
    assign o_copy.copy_src_addr   = r_copy_src_addr;
    assign o_copy.copy_dst_addr   = r_copy_dst_addr;
    assign o_copy.header_checksum = r_header_checksum;
    assign o_copy.last_copy       = r_last_copy;

    // A slot being emitted was active when the walk started
    a_slot_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> r_valid[r_slot])
        else $error("walking an inactive route slot");

    // Base sum state is always followed directly by S_CALC
    a_base_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BASE) |=> (r_state == S_CALC))
        else $error("base sum state did not advance");

    // A packet with no active route produces nothing and frees the block
    a_no_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.func == lpfr_pkg::FUNC_PACKET) && (r_valid == '0))
        |=> (r_state == S_IDLE))
        else $error("packet without routes started a walk");

    // The final copy carries the last mark and ends the walk
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (calc_go && last_now) |=> ((r_state == S_IDLE) && o_copy.valid && o_copy.last_copy))
        else $error("final copy without last mark");

endmodule

`default_nettype wire
